/* design/cpa_pkg.sv */
// Package for the contiguous page allocator: sizes, codes and the
// transaction types passed between the front end, command queue and back end.
// No dependencies.
`default_nettype none
package cpa_pkg;
	localparam int MAX_PAGES    = 256;
	localparam int HEADER_BYTES = 16;
	localparam int PAGE_W       = $clog2(MAX_PAGES);
	localparam int CNT_W        = $clog2(MAX_PAGES + 1);
	localparam int IDX_W        = CNT_W + 1;
	localparam int REQ_W        = 24;
	localparam int ACT_W        = REQ_W + 1;
	localparam int PB_W         = 17;
	localparam int ALIGN_W      = 16;
	localparam int BYTES_W      = 32;
	localparam int DIV_CNT_W    = $clog2(ACT_W + 1);
	localparam int REC_W        = 1 + PAGE_W + CNT_W + REQ_W;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic REG_PAGE_BYTES = 1'b0;
	localparam logic REG_POOL_PAGES = 1'b1;
	localparam logic [PB_W-1:0]  PAGE_BYTES_RST = PB_W'(4096);
	localparam logic [CNT_W-1:0] POOL_PAGES_RST = '0;

	typedef enum logic [2:0] {
		ST_OK, ST_ZERO, ST_TOO_LARGE, ST_ALIGN, ST_NO_SPACE, ST_NOT_ALLOC
	} status_t;

	typedef enum logic [1:0] {K_DONE, K_ALLOC, K_FREE, K_QUERY} kind_t;

	typedef struct packed {
		kind_t              kind;
		status_t            status;
		logic [REQ_W-1:0]   req;
		logic [CNT_W-1:0]   need;
		logic [PAGE_W-1:0]  ref_page;
	} cmd_t;

	typedef struct packed {
		logic              owned;
		logic [PAGE_W-1:0] start;
		logic [CNT_W-1:0]  len;
		logic [REQ_W-1:0]  bytes;
	} rec_t;

	typedef struct packed {
		status_t             status;
		logic [PAGE_W-1:0]   start;
		logic [REQ_W-1:0]    region;
		logic [CNT_W-1:0]    pages;
		logic [BYTES_W-1:0]  bytes;
	} res_t;

	typedef enum logic [1:0] {F_IDLE, F_CHECK, F_DIV, F_PUSH} fstate_t;

	typedef enum logic [3:0] {
		B_INIT, B_IDLE, B_SCAN, B_TEST, B_PROBE, B_PTEST, B_GRANT, B_LOOK, B_CLEAR, B_EMIT
	} bstate_t;
endpackage
`default_nettype wire

/* design/cpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

/* design/cpa_front.sv */
// Front end: takes an input transaction, screens it and works out the page
// count with a bit-serial divider. Depends on cpa_pkg.
`default_nettype none
module cpa_front import cpa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           opcode,
	input  wire logic [REQ_W-1:0]     request_bytes,
	input  wire logic [ALIGN_W-1:0]   align_request,
	input  wire logic [PAGE_W-1:0]    page_ref,
	input  wire logic [CNT_W-1:0]     pool_pages,
	input  wire logic [PB_W-1:0]      page_bytes_eff,
	output logic                      cmd_push,
	output cmd_t                      cmd,
	input  wire logic                 cmd_full
);
	fstate_t state_q, state_d;
	logic [1:0]          op_q;
	logic [REQ_W-1:0]    req_q;
	logic [ALIGN_W-1:0]  align_q;
	logic [PAGE_W-1:0]   ref_q;
	cmd_t                cmd_q;
	logic [ACT_W-1:0]    dvd_q;
	logic [PB_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [ACT_W-1:0]       actual;
	logic [CNT_W+PB_W-1:0]  region;
	logic                   too_large;
	logic [PB_W:0]          rem_sh;
	logic                   q_bit;
	logic [PB_W:0]          rem_sub;
	logic                   div_last;

	assign actual    = ACT_W'(req_q) + ACT_W'(HEADER_BYTES);
	assign region    = (CNT_W+PB_W)'(pool_pages) * (CNT_W+PB_W)'(page_bytes_eff);
	assign too_large = (CNT_W+PB_W)'(actual) > region;
	assign rem_sh    = {rem_q, dvd_q[ACT_W-1]};
	assign q_bit     = rem_sh >= {1'b0, page_bytes_eff};
	assign rem_sub   = rem_sh - {1'b0, page_bytes_eff};
	assign div_last  = cnt_q == DIV_CNT_W'(ACT_W - 1);

	assign full     = state_q != F_IDLE;
	assign cmd_push = (state_q == F_PUSH) && !cmd_full;
	assign cmd      = cmd_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (push) begin
					state_d = F_CHECK;
				end
			end
			F_CHECK: begin
				if (op_q == OP_ALLOC && req_q != '0 && !too_large && align_q == '0) begin
					state_d = F_DIV;
				end else begin
					state_d = F_PUSH;
				end
			end
			F_DIV: begin
				if (div_last) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!cmd_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				op_q    <= opcode;
				req_q   <= request_bytes;
				align_q <= align_request;
				ref_q   <= page_ref;
			end
			F_CHECK: begin
				cmd_q.req      <= req_q;
				cmd_q.ref_page <= ref_q;
				cmd_q.need     <= '0;
				cmd_q.status   <= ST_OK;
				cmd_q.kind     <= K_DONE;
				dvd_q          <= actual;
				rem_q          <= '0;
				cnt_q          <= '0;
				case (op_q)
					OP_ALLOC: begin
						if (req_q == '0) begin
							cmd_q.status <= ST_ZERO;
						end else if (too_large) begin
							cmd_q.status <= ST_TOO_LARGE;
						end else if (align_q != '0) begin
							cmd_q.status <= ST_ALIGN;
						end
					end
					OP_FREE:  cmd_q.kind <= K_FREE;
					OP_QUERY: cmd_q.kind <= K_QUERY;
					default:  cmd_q.status <= ST_NOT_ALLOC;
				endcase
			end
			F_DIV: begin
				rem_q <= q_bit ? rem_sub[PB_W-1:0] : rem_sh[PB_W-1:0];
				dvd_q <= {dvd_q[ACT_W-2:0], q_bit};
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					if ({dvd_q[ACT_W-2:0], q_bit} >= ACT_W'(MAX_PAGES)) begin
						cmd_q.status <= ST_NO_SPACE;
					end else begin
						cmd_q.kind <= K_ALLOC;
						cmd_q.need <= CNT_W'({dvd_q[ACT_W-2:0], q_bit}) + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* design/cpa_cmd_q.sv */
// Two-entry command queue between the front end and the back end.
// Depends on cpa_pkg.
`default_nettype none
module cpa_cmd_q import cpa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  cmd_t      wr_data,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      empty
);
	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule
`default_nettype wire

/* design/cpa_back.sv */
// Back end: first-fit scan, page grant and release over the page record RAM, the
// counters, and a two-entry result queue. Depends on cpa_pkg and cpa_ram.
`default_nettype none
module cpa_back import cpa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_empty,
	input  cmd_t                    cmd,
	output logic                    cmd_pop,
	input  wire logic [CNT_W-1:0]   pool_pages,
	output logic                    empty,
	input  wire logic               pop,
	output res_t                    res
);
	bstate_t state_q, state_d;
	cmd_t                cur_q;
	logic [IDX_W-1:0]    i_q;
	logic [CNT_W-1:0]    k_q;
	logic [PAGE_W-1:0]   init_q;
	logic [CNT_W-1:0]    hint_q;
	logic [CNT_W-1:0]    pages_q;
	logic [BYTES_W-1:0]  bytes_q;
	rec_t                rec_q;
	status_t             st_q;
	logic [PAGE_W-1:0]   start_q;
	logic [REQ_W-1:0]    rbytes_q;

	res_t       res_mem_q [2];
	logic       res_wr_q, res_rd_q;
	logic [1:0] res_cnt_q;
	logic       res_push, res_pop;

	logic              ram_we;
	logic [PAGE_W-1:0] ram_waddr, ram_raddr;
	rec_t              ram_wdata, ram_rdata;

	logic [IDX_W-1:0]  n_ext, ik, next_pg, ck, i_need;
	logic [PAGE_W-1:0] gidx;
	logic              scan_end, probe_go, no_fit, grant_last, init_last;
	logic              ref_in, clear_go;
	logic [BYTES_W:0]  bytes_sum;

	assign n_ext      = IDX_W'(pool_pages);
	assign ik         = i_q + IDX_W'(k_q);
	assign i_need     = i_q + IDX_W'(cur_q.need);
	assign gidx       = ik[PAGE_W-1:0];
	assign next_pg    = IDX_W'(ram_rdata.start) + IDX_W'(ram_rdata.len);
	assign ck         = IDX_W'(rec_q.start) + IDX_W'(k_q);
	assign scan_end   = i_q >= n_ext;
	assign probe_go   = (k_q < cur_q.need) && (ik < n_ext);
	assign no_fit     = i_need > n_ext;
	assign grant_last = k_q == cur_q.need - 1'b1;
	assign init_last  = init_q == PAGE_W'(MAX_PAGES - 1);
	assign ref_in     = CNT_W'(cmd.ref_page) < pool_pages;
	assign clear_go   = (k_q < rec_q.len) && (ck < IDX_W'(MAX_PAGES));
	assign bytes_sum  = {1'b0, bytes_q} + (BYTES_W+1)'(cur_q.req);

	assign cmd_pop   = (state_q == B_IDLE) && !cmd_empty;
	assign res_push  = (state_q == B_EMIT) && (res_cnt_q != 2'd2);
	assign empty     = res_cnt_q == 2'd0;
	assign res_pop   = pop && !empty;
	assign res       = res_mem_q[res_rd_q];

	assign ram_we          = (state_q == B_INIT) || (state_q == B_GRANT) ||
		((state_q == B_CLEAR) && clear_go);
	assign ram_wdata.owned = state_q == B_GRANT;
	assign ram_wdata.start = i_q[PAGE_W-1:0];
	assign ram_wdata.len   = cur_q.need;
	assign ram_wdata.bytes = cur_q.req;

	always_comb begin
		case (state_q)
			B_INIT:  ram_waddr = init_q;
			B_CLEAR: ram_waddr = ck[PAGE_W-1:0];
			default: ram_waddr = gidx;
		endcase
		case (state_q)
			B_IDLE:  ram_raddr = cmd.ref_page;
			B_PROBE: ram_raddr = gidx;
			default: ram_raddr = i_q[PAGE_W-1:0];
		endcase
	end

	cpa_ram #(.WIDTH(REC_W), .DEPTH(MAX_PAGES)) u_rec_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT: begin
				if (init_last) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						K_ALLOC: state_d = B_SCAN;
						K_FREE, K_QUERY: state_d = ref_in ? B_LOOK : B_EMIT;
						default: state_d = B_EMIT;
					endcase
				end
			end
			B_SCAN: state_d = scan_end ? B_EMIT : B_TEST;
			B_TEST: state_d = ram_rdata.owned ? B_SCAN : B_PROBE;
			B_PROBE: begin
				if (probe_go) begin
					state_d = B_PTEST;
				end else begin
					state_d = no_fit ? B_EMIT : B_GRANT;
				end
			end
			B_PTEST: state_d = ram_rdata.owned ? B_SCAN : B_PROBE;
			B_GRANT: begin
				if (grant_last) begin
					state_d = B_EMIT;
				end
			end
			B_LOOK: begin
				if (!ram_rdata.owned || cur_q.kind == K_QUERY) begin
					state_d = B_EMIT;
				end else begin
					state_d = B_CLEAR;
				end
			end
			B_CLEAR: begin
				if (!clear_go) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (res_cnt_q != 2'd2) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			init_q  <= '0;
			hint_q  <= '0;
			pages_q <= '0;
			bytes_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_INIT: begin
					init_q <= init_q + 1'b1;
				end
				B_GRANT: begin
					if (grant_last) begin
						if (i_q >= IDX_W'(hint_q)) begin
							hint_q <= i_need[CNT_W-1:0];
						end
						pages_q <= pages_q + cur_q.need;
						bytes_q <= bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
					end
				end
				B_CLEAR: begin
					if (!clear_go) begin
						pages_q <= (pages_q > rec_q.len) ? pages_q - rec_q.len : '0;
						bytes_q <= (bytes_q > BYTES_W'(rec_q.bytes)) ?
							bytes_q - BYTES_W'(rec_q.bytes) : '0;
						if (CNT_W'(rec_q.start) < hint_q) begin
							hint_q <= CNT_W'(rec_q.start);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cur_q    <= cmd;
				i_q      <= IDX_W'(hint_q);
				k_q      <= '0;
				st_q     <= (cmd.kind == K_DONE) ? cmd.status : ST_NOT_ALLOC;
				start_q  <= '0;
				rbytes_q <= '0;
			end
			B_SCAN: begin
				if (scan_end) begin
					st_q <= ST_NO_SPACE;
				end
			end
			B_TEST: begin
				if (ram_rdata.owned) begin
					i_q <= (next_pg > i_q) ? next_pg : i_q + 1'b1;
				end else begin
					k_q <= CNT_W'(1);
				end
			end
			B_PROBE: begin
				if (!probe_go) begin
					if (no_fit) begin
						st_q <= ST_NO_SPACE;
					end else begin
						k_q <= '0;
					end
				end
			end
			B_PTEST: begin
				if (ram_rdata.owned) begin
					i_q <= ik;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			B_GRANT: begin
				k_q <= k_q + 1'b1;
				if (grant_last) begin
					st_q     <= ST_OK;
					start_q  <= i_q[PAGE_W-1:0];
					rbytes_q <= cur_q.req;
				end
			end
			B_LOOK: begin
				if (ram_rdata.owned) begin
					rec_q    <= ram_rdata;
					k_q      <= '0;
					st_q     <= ST_OK;
					start_q  <= ram_rdata.start;
					rbytes_q <= ram_rdata.bytes;
				end
			end
			B_CLEAR: begin
				k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
		if (res_push) begin
			res_mem_q[res_wr_q].status <= st_q;
			res_mem_q[res_wr_q].start  <= start_q;
			res_mem_q[res_wr_q].region <= rbytes_q;
			res_mem_q[res_wr_q].pages  <= pages_q;
			res_mem_q[res_wr_q].bytes  <= bytes_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_GRANT) |-> (ik < n_ext))
		else $error("grant outside the pool");
	a_probe_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PTEST) |-> (ik < n_ext))
		else $error("probe outside the pool");
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q <= CNT_W'(MAX_PAGES))
		else $error("page count above pool limit");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT && res_cnt_q == 2'd2 && !res_pop) |=> (state_q == B_EMIT))
		else $error("result dropped on full queue");
endmodule
`default_nettype wire

/* design/contiguous_page_allocator_unit.sv */
// Top level of the contiguous page allocator: config registers, front end, command queue
// and back end. Depends on cpa_pkg, cpa_front, cpa_cmd_q, cpa_back and cpa_ram.
// A result follows front-end screening, the divider for an allocate, and a scan and
// grant, a lookup, or a lookup and release of the region in the back end.
// The front end takes a new transaction only once it has queued the last one.
// Reset clears hint and counters at once, then a pass clears every page record.
`default_nettype none
module contiguous_page_allocator_unit import cpa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         opcode,
	input  wire logic [REQ_W-1:0]   request_bytes,
	input  wire logic [ALIGN_W-1:0] align_request,
	input  wire logic [PAGE_W-1:0]  page_ref,
	output logic                    empty,
	input  wire logic               pop,
	output logic [2:0]              status,
	output logic [PAGE_W-1:0]       start_page,
	output logic [REQ_W-1:0]        region_bytes,
	output logic [CNT_W-1:0]        pages_taken,
	output logic [BYTES_W-1:0]      bytes_taken,
	input  wire logic               cfg_we,
	input  wire logic               cfg_addr,
	input  wire logic [PB_W-1:0]    cfg_wdata
);
	logic [PB_W-1:0]  page_bytes_q;
	logic [CNT_W-1:0] pool_pages_q;
	logic [PB_W-1:0]  page_bytes_eff;
	logic [CNT_W-1:0] pool_eff;

	cmd_t f_cmd, q_cmd;
	logic f_push, q_full, q_empty, b_pop;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_BYTES_RST;
			pool_pages_q <= POOL_PAGES_RST;
		end else if (cfg_we) begin
			if (cfg_addr == REG_PAGE_BYTES) begin
				page_bytes_q <= cfg_wdata;
			end else begin
				pool_pages_q <= cfg_wdata[CNT_W-1:0];
			end
		end
	end

	assign page_bytes_eff = (page_bytes_q < PB_W'(HEADER_BYTES)) ?
		PB_W'(HEADER_BYTES) : page_bytes_q;
	assign pool_eff = (pool_pages_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pool_pages_q;

	cpa_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.align_request  (align_request),
		.page_ref       (page_ref),
		.pool_pages     (pool_eff),
		.page_bytes_eff (page_bytes_eff),
		.cmd_push       (f_push),
		.cmd            (f_cmd),
		.cmd_full       (q_full)
	);

	cpa_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_cmd),
		.full    (q_full),
		.rd_en   (b_pop),
		.rd_data (q_cmd),
		.empty   (q_empty)
	);

	cpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (q_empty),
		.cmd        (q_cmd),
		.cmd_pop    (b_pop),
		.pool_pages (pool_eff),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign status       = res.status;
	assign start_page   = res.start;
	assign region_bytes = res.region;
	assign pages_taken  = res.pages;
	assign bytes_taken  = res.bytes;
endmodule
`default_nettype wire
